// ===== rtl/dtnf_pkg.sv =====
package dtnf_pkg;

  localparam int unsigned FRACTION_DIGITS_DEF = 9;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_INT   = 2'd1,
    PH_FRAC  = 2'd2
  } phase_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    case (n)
      0: r = 64'd1;
      1: r = 64'd10;
      2: r = 64'd100;
      3: r = 64'd1000;
      4: r = 64'd10000;
      5: r = 64'd100000;
      6: r = 64'd1000000;
      7: r = 64'd10000000;
      8: r = 64'd100000000;
      9: r = 64'd1000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/decimal_text_to_nano_fixed.sv =====
// Characters are taken at one transaction per cycle while item_stall is low and produce no result.
// An end marker's result passes, once it is taken, through a two-entry queue
// and a three-stage scale, add and range pipeline.
// Sustained throughput is one transaction per cycle while the output is not stalled.
// Reset (rst, synchronous, active high) empties the queue and pipeline and
// returns the parser to the start of a new text.
module decimal_text_to_nano_fixed import dtnf_pkg::*; #(
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               opcode,
  input  logic [7:0]         ch,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] mantissa,
  output logic [1:0]         status
);

  localparam logic [63:0] SCALE = pow10(int'(FRACTION_DIGITS));
  localparam logic [63:0] MAX_WHOLE = POS_LIMIT / SCALE;
  localparam int unsigned WHOLE_W = $clog2(MAX_WHOLE + 64'd1);
  localparam int unsigned FRAC_W = $clog2(SCALE);
  localparam int unsigned JOB_W = WHOLE_W + FRAC_W + 3;

  logic             accept;
  logic             push;
  logic [JOB_W-1:0] job_in, job_out;
  logic             q_full, q_nonempty, q_pop;

  assign item_stall = q_full;
  assign accept = item_valid && !item_stall;

  dtnf_front #(
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .WHOLE_W(WHOLE_W),
    .FRAC_W(FRAC_W),
    .MAX_WHOLE(MAX_WHOLE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .opcode(opcode),
    .ch(ch),
    .push(push),
    .job(job_in)
  );

  dtnf_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(job_in),
    .pop(q_pop),
    .full(q_full),
    .nonempty(q_nonempty),
    .rdata(job_out)
  );

  dtnf_back #(
    .WHOLE_W(WHOLE_W),
    .FRAC_W(FRAC_W),
    .SCALE(SCALE)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(q_nonempty),
    .job(job_out),
    .job_pop(q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .mantissa(mantissa),
    .status(status)
  );

endmodule

// ===== rtl/dtnf_front.sv =====
module dtnf_front import dtnf_pkg::*; #(
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int unsigned WHOLE_W = 34,
  parameter int unsigned FRAC_W = 30,
  parameter logic [63:0] MAX_WHOLE = 64'd9223372036
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           opcode,
  input  logic [7:0]                     ch,
  output logic                           push,
  output logic [WHOLE_W+FRAC_W+2:0]      job
);

  localparam int unsigned CNT_W = $clog2(FRACTION_DIGITS + 1);

  phase_t               phase, phase_next;
  logic                 is_negative, is_negative_next;
  logic                 int_digit_seen, int_digit_seen_next;
  logic [WHOLE_W-1:0]   whole_part, whole_part_next;
  logic [FRAC_W-1:0]    frac_nanos, frac_nanos_next;
  logic [CNT_W-1:0]     frac_count, frac_count_next;
  status_t              latched_error, latched_error_next;

  logic [3:0]           digit;
  logic                 num_char;
  logic [WHOLE_W+3:0]   whole_x10;
  logic [63:0]          weight;
  status_t              end_status;

  assign digit = ch[3:0];
  assign num_char = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign whole_x10 = ({4'b0, whole_part} << 3) + ({4'b0, whole_part} << 1)
                   + (WHOLE_W+4)'(digit);
  assign weight = pow10(int'(FRACTION_DIGITS) - 1 - int'(frac_count));

  always_comb begin
    if (latched_error != ST_OK) begin
      end_status = latched_error;
    end else if (!int_digit_seen) begin
      end_status = ST_PARSE;
    end else begin
      end_status = ST_OK;
    end
  end

  assign push = accept && (opcode == OP_END);
  assign job = {is_negative, end_status, whole_part, frac_nanos};

  always_comb begin
    phase_next          = phase;
    is_negative_next    = is_negative;
    int_digit_seen_next = int_digit_seen;
    whole_part_next     = whole_part;
    frac_nanos_next     = frac_nanos;
    frac_count_next     = frac_count;
    latched_error_next  = latched_error;
    if (accept && (opcode == OP_END)) begin
      phase_next          = PH_START;
      is_negative_next    = 1'b0;
      int_digit_seen_next = 1'b0;
      whole_part_next     = '0;
      frac_nanos_next     = '0;
      frac_count_next     = '0;
      latched_error_next  = ST_OK;
    end else if (accept && (latched_error == ST_OK)) begin
      if ((phase == PH_START) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
        is_negative_next = (ch == CH_MINUS);
        phase_next = PH_INT;
      end else if ((phase == PH_START) || (phase == PH_INT)) begin
        if (num_char) begin
          if (whole_x10 > (WHOLE_W+4)'(MAX_WHOLE)) begin
            latched_error_next = ST_RANGE;
          end else begin
            whole_part_next = whole_x10[WHOLE_W-1:0];
            int_digit_seen_next = 1'b1;
            phase_next = PH_INT;
          end
        end else if ((ch == CH_DOT) && int_digit_seen) begin
          phase_next = PH_FRAC;
        end else begin
          latched_error_next = ST_PARSE;
        end
      end else if (num_char) begin
        if (frac_count >= CNT_W'(FRACTION_DIGITS)) begin
          latched_error_next = ST_PARSE;
        end else begin
          frac_nanos_next = frac_nanos + FRAC_W'(64'(digit) * weight);
          frac_count_next = frac_count + CNT_W'(1);
        end
      end else begin
        latched_error_next = ST_PARSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      is_negative    <= 1'b0;
      int_digit_seen <= 1'b0;
      whole_part     <= '0;
      frac_nanos     <= '0;
      frac_count     <= '0;
      latched_error  <= ST_OK;
    end else begin
      phase          <= phase_next;
      is_negative    <= is_negative_next;
      int_digit_seen <= int_digit_seen_next;
      whole_part     <= whole_part_next;
      frac_nanos     <= frac_nanos_next;
      frac_count     <= frac_count_next;
      latched_error  <= latched_error_next;
    end
  end

`ifndef SYNTHESIS
  a_frac_count_bound: assert property (@(posedge clk) disable iff (rst)
    frac_count <= CNT_W'(FRACTION_DIGITS))
    else $error("Fraction digit count passed its limit.");

  a_whole_bound: assert property (@(posedge clk) disable iff (rst)
    64'(whole_part) <= MAX_WHOLE)
    else $error("Whole part passed its limit.");
`endif

endmodule

// ===== rtl/dtnf_queue.sv =====
module dtnf_queue import dtnf_pkg::*; #(
  parameter int unsigned WIDTH = 67,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + CNT_W'(1);
        2'b01: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Queue count passed its depth.");
`endif

endmodule

// ===== rtl/dtnf_back.sv =====
module dtnf_back import dtnf_pkg::*; #(
  parameter int unsigned WHOLE_W = 34,
  parameter int unsigned FRAC_W = 30,
  parameter logic [63:0] SCALE = 64'd1000000000
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  logic [WHOLE_W+FRAC_W+2:0] job,
  output logic                      job_pop,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [63:0]        mantissa,
  output logic [1:0]                status
);

  logic                en;
  logic                v1, v2;
  logic                neg1, neg2;
  status_t             st1, st2;
  logic [63:0]         prod1, mag2;
  logic [FRAC_W-1:0]   frac1;
  logic                over;

  assign en = !result_valid || !result_stall;
  assign job_pop = job_valid && en;
  assign over = neg2 ? (mag2 > NEG_LIMIT) : (mag2 > POS_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= job_valid;
      v2 <= v1;
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= job[WHOLE_W+FRAC_W+2];
      st1   <= status_t'(job[WHOLE_W+FRAC_W+1:WHOLE_W+FRAC_W]);
      prod1 <= 64'(job[WHOLE_W+FRAC_W-1:FRAC_W]) * SCALE;
      frac1 <= job[FRAC_W-1:0];
      neg2  <= neg1;
      st2   <= st1;
      mag2  <= prod1 + 64'(frac1);
      if (st2 != ST_OK) begin
        mantissa <= '0;
        status   <= st2;
      end else if (over) begin
        mantissa <= '0;
        status   <= ST_RANGE;
      end else begin
        mantissa <= neg2 ? (~mag2 + 64'd1) : mag2;
        status   <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> mantissa == 64'sd0)
    else $error("A failed result carries a nonzero mantissa.");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en |=> v2 && $stable(mag2) && $stable(st2))
    else $error("The middle stage changed while the output was stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK) || (status == ST_PARSE) || (status == ST_RANGE))
    else $error("Result status holds an unused code.");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dtnf_pkg::*;

  localparam logic [63:0] NANO_SCALE = 64'd1000000000;
  localparam logic [63:0] WHOLE_CAP = POS_LIMIT / NANO_SCALE;
  localparam int RANDOM_ITEMS = 2000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic signed [63:0] mant;
    status_t st;
  } nano_value_t;

  typedef struct packed {
    logic op;
    logic [7:0] c;
    bit known;
    logic signed [63:0] mant;
    status_t st;
  } text_row_t;

  // Each end-marker row with a known value carries it; the other rows are predicted.
  text_row_t directed_rows [26] = '{
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, CH_PLUS,  1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, CH_DOT,   1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, 8'h37,    1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, CH_DOT,   1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'hFF,    1'b1, 64'sd7000000000, ST_OK},
    '{OP_CHAR, 8'hFF,    1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, 8'h00,    1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, 8'h31,    1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, CH_PLUS,  1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, CH_MINUS, 1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, 8'h35,    1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, -64'sd5000000000, ST_OK},
    '{OP_CHAR, 8'h31,    1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, CH_DOT,   1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, CH_DOT,   1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b1, 64'sd0, ST_PARSE},
    '{OP_CHAR, CH_ZERO,  1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, CH_DOT,   1'b0, 64'sd0, ST_OK},
    '{OP_CHAR, 8'h35,    1'b0, 64'sd0, ST_OK},
    '{OP_END,  8'h00,    1'b0, 64'sd0, ST_OK}
  };

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic opcode = OP_CHAR;
  logic [7:0] ch = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [63:0] mantissa;
  logic [1:0] status;

  bit literal_known = 1'b0;
  logic signed [63:0] literal_mant = '0;
  status_t literal_status = ST_OK;

  phase_t parse_phase = PH_START;
  bit minus_sign = 1'b0;
  bit digits_seen = 1'b0;
  logic [63:0] whole_acc = '0;
  logic [63:0] frac_acc = '0;
  logic [63:0] frac_weight = NANO_SCALE / 10;
  int frac_taken = 0;
  status_t first_error = ST_OK;

  nano_value_t expected_values[$];
  logic [7:0] text_chars[$];

  int items_taken = 0;
  int sent_items = 0;
  int text_no = 0;
  int mismatches = 0;
  int ok_seen = 0;
  int parse_seen = 0;
  int range_seen = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  decimal_text_to_nano_fixed dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .ch(ch),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .mantissa(mantissa),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void parse_char(input logic [7:0] c);
    logic [63:0] d;
    bit num_char;
    num_char = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 64'(c - CH_ZERO);
    if (first_error != ST_OK) return;
    if (parse_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
      minus_sign = (c == CH_MINUS);
      parse_phase = PH_INT;
    end else if (parse_phase != PH_FRAC) begin
      if (num_char) begin
        if (whole_acc > (WHOLE_CAP - d) / 10) begin
          first_error = ST_RANGE;
        end else begin
          whole_acc = whole_acc * 10 + d;
          digits_seen = 1'b1;
          parse_phase = PH_INT;
        end
      end else if (c == CH_DOT && digits_seen) begin
        parse_phase = PH_FRAC;
      end else begin
        first_error = ST_PARSE;
      end
    end else if (num_char) begin
      if (frac_taken >= 9) begin
        first_error = ST_PARSE;
      end else begin
        frac_acc = frac_acc + d * frac_weight;
        frac_weight = frac_weight / 10;
        frac_taken++;
      end
    end else begin
      first_error = ST_PARSE;
    end
  endfunction

  function automatic nano_value_t finish_text();
    nano_value_t v;
    logic [63:0] mag;
    v.mant = '0;
    v.st = ST_OK;
    if (first_error != ST_OK) begin
      v.st = first_error;
    end else if (!digits_seen) begin
      v.st = ST_PARSE;
    end else begin
      mag = whole_acc * NANO_SCALE + frac_acc;
      if (mag > (minus_sign ? NEG_LIMIT : POS_LIMIT)) v.st = ST_RANGE;
      else v.mant = minus_sign ? (~mag + 64'd1) : mag;
    end
    parse_phase = PH_START;
    minus_sign = 1'b0;
    digits_seen = 1'b0;
    whole_acc = '0;
    frac_acc = '0;
    frac_weight = NANO_SCALE / 10;
    frac_taken = 0;
    first_error = ST_OK;
    return v;
  endfunction

  function automatic void queue_char(input logic [7:0] c);
    text_chars = {text_chars, c};
  endfunction

  function automatic void add_number();
    string digs;
    int n_int;
    int n_frac;
    if ($urandom_range(0, 2) == 0) queue_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    if ($urandom_range(0, 99) < 15) begin
      digs = "922337203";
      digs = {digs, string'(8'(CH_ZERO + $urandom_range(5, 7)))};
      if ($urandom_range(0, 4) == 0) digs = {digs, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      if ($urandom_range(0, 3) != 0) begin
        digs = {digs, ".85477580"};
        digs = {digs, string'(8'(CH_ZERO + $urandom_range(6, 9)))};
      end
      for (int i = 0; i < digs.len(); i++) queue_char(8'(digs[i]));
    end else begin
      n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 3);
      for (int i = 0; i < n_int; i++) queue_char(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
        queue_char(CH_DOT);
        n_frac = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 11) : $urandom_range(0, 9);
        for (int i = 0; i < n_frac; i++) queue_char(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
  endfunction

  task automatic send_item(input logic op, input logic [7:0] c, input bit known,
                           input logic signed [63:0] m, input status_t s);
    int taken_before;
    while (!calm && $urandom_range(0, 99) < 34) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    taken_before = items_taken;
    item_valid <= 1'b1;
    opcode <= op;
    ch <= c;
    literal_known <= known;
    literal_mant <= m;
    literal_status <= s;
    do @(negedge clk); while (items_taken == taken_before);
    sent_items++;
  endtask

  always @(negedge clk) begin
    result_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    nano_value_t calc;
    nano_value_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        items_taken <= items_taken + 1;
        if (opcode == OP_END) begin
          calc = finish_text();
          if (literal_known) begin
            want.mant = literal_mant;
            want.st = literal_status;
          end else begin
            want = calc;
          end
          expected_values = {expected_values, want};
        end else begin
          parse_char(ch);
        end
      end
      if (result_valid && !result_stall) begin
        case (status)
          ST_OK: ok_seen++;
          ST_PARSE: parse_seen++;
          default: range_seen++;
        endcase
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("Unexpected result: mantissa %0d status %0d", mantissa, status);
        end else begin
          want = expected_values.pop_front();
          if (mantissa !== want.mant || status !== want.st) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("Mismatch: expected mantissa %0d status %0d, got mantissa %0d status %0d",
                       want.mant, want.st, mantissa, status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind;
    int pos;
    logic [7:0] junk;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].c, directed_rows[i].known,
                directed_rows[i].mant, directed_rows[i].st);

    while (sent_items < RANDOM_ITEMS) begin
      text_no++;
      calm = (text_no >= 150 && text_no < 250);
      if (text_no % 200 == 100) begin
        item_valid <= 1'b0;
        @(negedge clk);
        while (expected_values.size() != 0) @(negedge clk);
      end
      text_chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 85) add_number();
      if (kind >= 70 && kind < 85) begin
        case ($urandom_range(0, 3))
          0: junk = CH_PLUS;
          1: junk = CH_MINUS;
          2: junk = CH_DOT;
          default: junk = 8'($urandom_range(0, 255));
        endcase
        pos = $urandom_range(0, text_chars.size());
        text_chars.insert(pos, junk);
      end else if (kind >= 85) begin
        repeat ($urandom_range(0, 5))
          queue_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(CH_PLUS, CH_NINE)));
      end
      foreach (text_chars[i]) send_item(OP_CHAR, text_chars[i], 1'b0, '0, ST_OK);
      send_item(OP_END, 8'($urandom_range(0, 255)), 1'b0, '0, ST_OK);
    end

    calm = 1'b0;
    item_valid <= 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Drove %0d transactions over %0d random texts plus the directed table.",
             sent_items, text_no);
    $display("Results: %0d in range, %0d rejected as malformed, %0d out of range.",
             ok_seen, parse_seen, range_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== decimal_text_to_nano_fixed.f =====
rtl/dtnf_pkg.sv
rtl/dtnf_front.sv
rtl/dtnf_queue.sv
rtl/dtnf_back.sv
rtl/decimal_text_to_nano_fixed.sv
tb/tb.sv
